// File: rtl/mres_pkg.sv
// ----------------------------------------------------------------------------
// mres_pkg: shared constants and types for the mini risc execute step
// Request codes, entry kinds, opcodes and memory entry layout.
// ----------------------------------------------------------------------------
package mres_pkg;
   localparam int MEM_DEPTH_DEF = 256;
   localparam int NUM_REGS_DEF  = 32;
   localparam logic [4:0] QUOT_REG = 5'd24;
   localparam logic [4:0] REM_REG  = 5'd25;

   localparam logic [1:0] REQ_LOAD = 2'd0;
   localparam logic [1:0] REQ_EXEC = 2'd1;
   localparam logic [1:0] REQ_SETPC = 2'd2;

   localparam logic [1:0] KIND_EMPTY = 2'd0;
   localparam logic [1:0] KIND_DATA  = 2'd1;
   localparam logic [1:0] KIND_INSTR = 2'd2;

   localparam logic [2:0] OP_RTYPE = 3'd0;
   localparam logic [2:0] OP_J     = 3'd1;
   localparam logic [2:0] OP_BNE   = 3'd2;
   localparam logic [2:0] OP_BEQ   = 3'd3;
   localparam logic [2:0] OP_LW    = 3'd4;
   localparam logic [2:0] OP_SW    = 3'd5;

   localparam logic [1:0] FN_ADD  = 2'd0;
   localparam logic [1:0] FN_SUB  = 2'd1;
   localparam logic [1:0] FN_MULT = 2'd2;
   localparam logic [1:0] FN_DIV  = 2'd3;

   // memory entry, kind tag stored with the payload in one word
   typedef struct packed {
      logic [1:0]  kind;
      logic [31:0] value;
      logic [2:0]  op;
      logic [1:0]  fn;
      logic [4:0]  rd;
      logic [4:0]  ra;
      logic [4:0]  rb;
      logic [7:0]  imm;
   } entry_type;

   localparam int ENTRY_W = $bits(entry_type);
endpackage

// File: rtl/mres_ram.sv
// ----------------------------------------------------------------------------
// mres_ram: generic single port write, single port read ram
// Synchronous write, registered read: data appears in the cycle after the address.
// ----------------------------------------------------------------------------
module mres_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule

// File: rtl/mres_div.sv
// ----------------------------------------------------------------------------
// mres_div: iterative signed divider
// Restoring division one quotient bit per cycle, truncating toward zero.
// ----------------------------------------------------------------------------
module mres_div (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [31:0] dividend,
   input  logic [31:0] divisor,
   output logic        done,
   output logic [31:0] quotient,
   output logic [31:0] remainder
);
   logic        busy_ff, busy_in;
   logic [5:0]  cnt_ff, cnt_in;
   logic [31:0] q_ff, q_in, r_ff, r_in, d_ff, d_in;
   logic        qneg_ff, qneg_in, rneg_ff, rneg_in;
   logic        done_ff, done_in;
   logic [32:0] trial;
   logic [31:0] ua, ub;

   assign ua = dividend[31] ? -dividend : dividend;
   assign ub = divisor[31] ? -divisor : divisor;
   assign trial = {r_ff, q_ff[31]} - {1'b0, d_ff};

   always_comb begin
      busy_in = busy_ff;
      cnt_in  = cnt_ff;
      q_in    = q_ff;
      r_in    = r_ff;
      d_in    = d_ff;
      qneg_in = qneg_ff;
      rneg_in = rneg_ff;
      done_in = 1'b0;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = 6'd32;
         q_in    = ua;
         r_in    = '0;
         d_in    = ub;
         qneg_in = dividend[31] ^ divisor[31];
         rneg_in = dividend[31];
      end else if (busy_ff) begin
         if (trial[32]) begin
            r_in = {r_ff[30:0], q_ff[31]};
            q_in = {q_ff[30:0], 1'b0};
         end else begin
            r_in = trial[31:0];
            q_in = {q_ff[30:0], 1'b1};
         end
         cnt_in = cnt_ff - 6'd1;
         if (cnt_ff == 6'd1) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff  <= cnt_in;
      q_ff    <= q_in;
      r_ff    <= r_in;
      d_ff    <= d_in;
      qneg_ff <= qneg_in;
      rneg_ff <= rneg_in;
   end

   assign done      = done_ff;
   assign quotient  = qneg_ff ? -q_ff : q_ff;
   assign remainder = rneg_ff ? -r_ff : r_ff;
endmodule

// File: rtl/mini_risc_execute_step.sv
// ----------------------------------------------------------------------------
// mini_risc_execute_step: tiny mips-like core, one request per beat
// Register file and tagged memory live in synchronous rams.
// ----------------------------------------------------------------------------
// One request is taken at a time. The result beat is made valid by S_OUT,
// reached through FETCH for load and set-pc; FETCH and DEC for an execute of
// an empty or data entry; FETCH, DEC, REGS and EXE for jump, branch, lw and
// sw; those and LWD for add, sub and mult; those, LWD and REM for div by zero;
// and for any other div also DIVW, which waits on the bit-serial divider. The
// next request can be taken in the cycle after the result is taken. After
// reset a clearing pass writes every memory entry empty and every register
// zero, during which no request is accepted. The result sits in an output
// register and is held until taken.
module mini_risc_execute_step
   import mres_pkg::*;
#(
   parameter int MEM_DEPTH = MEM_DEPTH_DEF,
   parameter int NUM_REGS  = NUM_REGS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // tdata: address[7:0], word_kind[9:8], data_value[41:10], opcode[44:42],
   // funct[46:45], dest_reg[51:47], src_a[56:52], src_b[61:57],
   // immediate[69:62], zero fill to 72
   input  logic [71:0] req_tdata,
   // tuser: req_type[1:0]
   input  logic [1:0]  req_tuser,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // tdata: pc_now[7:0], write_a_valid[8], write_a_reg[13:9],
   // write_a_value[45:14], write_b_valid[46], write_b_value[78:47],
   // store_valid[79], store_address[87:80], store_value[119:88]
   output logic [119:0] rsp_tdata
);
   localparam int AW = $clog2(MEM_DEPTH);
   localparam int CLR_N = (MEM_DEPTH > 32) ? MEM_DEPTH : 32;
   localparam int CW = $clog2(CLR_N);

   localparam logic [3:0] S_CLEAR = 4'd0;
   localparam logic [3:0] S_IDLE  = 4'd1;
   localparam logic [3:0] S_FETCH = 4'd2;
   localparam logic [3:0] S_DEC   = 4'd3;
   localparam logic [3:0] S_REGS  = 4'd4;
   localparam logic [3:0] S_EXE   = 4'd5;
   localparam logic [3:0] S_LWD   = 4'd6;
   localparam logic [3:0] S_DIVW  = 4'd7;
   localparam logic [3:0] S_REM   = 4'd8;
   localparam logic [3:0] S_OUT   = 4'd9;

   logic [3:0] state_ff, state_in;
   logic [CW-1:0] clr_ff, clr_in;
   logic [AW-1:0] pc_ff, pc_in;
   logic [71:0] req_ff;
   logic [1:0]  typ_ff;
   entry_type   ent_ff;
   logic [31:0] a_ff, b_ff;
   logic        out_v_ff, out_v_in;
   logic [119:0] out_ff, out_in;

   // memory ports
   logic           m_we;
   logic [AW-1:0]  m_wa, m_ra;
   entry_type      m_wd, m_rd;
   logic           r_we;
   logic [4:0]     r_wa, r_ra;
   logic [31:0]    r_wd, r_rd;

   mres_ram #(.WIDTH(ENTRY_W), .DEPTH(MEM_DEPTH)) u_mem (
      .clock(clock), .wr_en(m_we), .wr_addr(m_wa), .wr_data(m_wd),
      .rd_addr(m_ra), .rd_data(m_rd));

   mres_ram #(.WIDTH(32), .DEPTH(32)) u_regs (
      .clock(clock), .wr_en(r_we), .wr_addr(r_wa), .wr_data(r_wd),
      .rd_addr(r_ra), .rd_data(r_rd));

   logic        dv_start, dv_done;
   logic [31:0] dv_q, dv_r;
   mres_div u_div (
      .clock(clock), .reset(reset), .start(dv_start), .dividend(a_ff),
      .divisor(b_ff), .done(dv_done), .quotient(dv_q), .remainder(dv_r));

   // 8-bit address modulo MEM_DEPTH by compare and subtract of scaled depths
   function automatic logic [AW-1:0] wrap_addr(logic [7:0] v);
      logic [19:0] w;
      w = 20'(v);
      for (int k = 3; k >= 0; k--) begin
         if (w >= (20'(MEM_DEPTH) << k)) w = w - (20'(MEM_DEPTH) << k);
      end
      return AW'(w);
   endfunction

   logic [AW-1:0] tgt, nxt;
   logic [31:0] addv, subv, mulv;
   logic a_ok, rd_ok;
   assign tgt  = wrap_addr(ent_ff.imm);
   assign nxt  = (pc_ff == AW'(MEM_DEPTH - 1)) ? '0 : pc_ff + AW'(1);
   assign mulv = a_ff * b_ff;
   assign addv = a_ff + b_ff;
   assign subv = a_ff - b_ff;
   assign rd_ok = 32'(ent_ff.rd) < NUM_REGS;
   assign a_ok  = 32'(QUOT_REG) < NUM_REGS;

   assign req_tready = (state_ff == S_IDLE) && !out_v_ff;

   function automatic logic [119:0] pack_out(logic [7:0] pcv, logic wav,
      logic [4:0] war, logic [31:0] wad, logic wbv, logic [31:0] wbd,
      logic sv, logic [7:0] sa, logic [31:0] sd);
      return {sd, sa, sv, wbd, wbv, wad, war, wav, pcv};
   endfunction

   always_comb begin
      state_in = state_ff;
      clr_in   = clr_ff;
      pc_in    = pc_ff;
      out_v_in = out_v_ff && !rsp_tready;
      out_in   = out_ff;
      m_we = 1'b0; m_wa = pc_ff; m_wd = '0; m_ra = pc_ff;
      r_we = 1'b0; r_wa = '0; r_wd = '0; r_ra = ent_ff.ra;
      dv_start = 1'b0;
      unique case (state_ff)
         S_CLEAR: begin
            m_we = 1'b1; m_wa = AW'(clr_ff);
            r_we = 1'b1; r_wa = clr_ff[4:0];
            clr_in = clr_ff + CW'(1);
            if (clr_ff == CW'(CLR_N - 1)) state_in = S_IDLE;
         end
         S_IDLE: begin
            if (req_tvalid && req_tready) state_in = S_FETCH;
         end
         S_FETCH: begin
            state_in = S_OUT;
            if (typ_ff == REQ_LOAD) begin
               m_we = 1'b1;
               m_wa = wrap_addr(req_ff[7:0]);
               if (req_ff[9:8] == KIND_DATA) begin
                  m_wd.kind = KIND_DATA; m_wd.value = req_ff[41:10];
               end else if (req_ff[9:8] == KIND_INSTR) begin
                  m_wd.kind = KIND_INSTR;
                  m_wd.op = req_ff[44:42]; m_wd.fn = req_ff[46:45];
                  m_wd.rd = req_ff[51:47]; m_wd.ra = req_ff[56:52];
                  m_wd.rb = req_ff[61:57]; m_wd.imm = req_ff[69:62];
               end
               out_in = pack_out(8'(pc_ff), 1'b0, '0, '0, 1'b0, '0, 1'b0, '0, '0);
            end else if (typ_ff == REQ_SETPC) begin
               pc_in  = wrap_addr(req_ff[7:0]);
               out_in = pack_out(8'(wrap_addr(req_ff[7:0])), 1'b0, '0, '0, 1'b0, '0,
                                 1'b0, '0, '0);
            end else if (typ_ff == REQ_EXEC) begin
               m_ra = pc_ff;
               state_in = S_DEC;
            end else begin
               out_in = pack_out(8'(pc_ff), 1'b0, '0, '0, 1'b0, '0, 1'b0, '0, '0);
            end
         end
         S_DEC: begin
            // entry in m_rd; read ra now
            r_ra = m_rd.ra;
            if (m_rd.kind != KIND_INSTR) begin
               pc_in = nxt;
               out_in = pack_out(8'(nxt), 1'b0, '0, '0, 1'b0, '0, 1'b0, '0, '0);
               state_in = S_OUT;
            end else begin
               state_in = S_REGS;
            end
         end
         S_REGS: begin
            r_ra = (ent_ff.op == OP_SW) ? ent_ff.rd : ent_ff.rb;
            m_ra = tgt;
            state_in = S_EXE;
         end
         S_EXE: begin
            // a_ff valid, b comes from r_rd this cycle (latched below)
            state_in = S_OUT;
            pc_in = nxt;
            out_in = pack_out(8'(nxt), 1'b0, '0, '0, 1'b0, '0, 1'b0, '0, '0);
            unique case (ent_ff.op)
               OP_J: begin
                  pc_in = tgt;
                  out_in = pack_out(8'(tgt), 1'b0, '0, '0, 1'b0, '0, 1'b0, '0, '0);
               end
               OP_BNE, OP_BEQ: begin
                  if ((a_ff != r_rd) == (ent_ff.op == OP_BNE)) begin
                     pc_in = tgt;
                     out_in = pack_out(8'(tgt), 1'b0, '0, '0, 1'b0, '0, 1'b0,
                                       '0, '0);
                  end
               end
               OP_LW: begin
                  if (rd_ok) begin
                     r_we = 1'b1; r_wa = ent_ff.rd;
                     r_wd = (m_rd.kind == KIND_DATA) ? m_rd.value : '0;
                     out_in = pack_out(8'(nxt), 1'b1, ent_ff.rd, r_wd, 1'b0, '0,
                                       1'b0, '0, '0);
                  end
               end
               OP_SW: begin
                  m_we = 1'b1; m_wa = tgt;
                  m_wd.kind = KIND_DATA;
                  m_wd.value = rd_ok ? r_rd : '0;
                  out_in = pack_out(8'(nxt), 1'b0, '0, '0, 1'b0, '0, 1'b1,
                                    8'(tgt), m_wd.value);
               end
               OP_RTYPE: begin
                  state_in = S_LWD;
               end
               default: ;
            endcase
         end
         S_LWD: begin
            // r-type with both operands registered
            state_in = S_OUT;
            unique case (ent_ff.fn)
               FN_ADD, FN_SUB: begin
                  if (rd_ok) begin
                     r_we = 1'b1; r_wa = ent_ff.rd;
                     r_wd = (ent_ff.fn == FN_ADD) ? addv : subv;
                     out_in = pack_out(8'(pc_ff), 1'b1, ent_ff.rd, r_wd, 1'b0, '0,
                                       1'b0, '0, '0);
                  end
               end
               FN_MULT: begin
                  if (a_ok) begin
                     r_we = 1'b1; r_wa = QUOT_REG; r_wd = mulv;
                     out_in = pack_out(8'(pc_ff), 1'b1, QUOT_REG, mulv, 1'b0, '0,
                                       1'b0, '0, '0);
                  end
               end
               FN_DIV: begin
                  dv_start = (b_ff != '0);
                  state_in = (b_ff != '0) ? S_DIVW : S_REM;
               end
               default: ;
            endcase
         end
         S_DIVW: begin
            if (dv_done) state_in = S_REM;
         end
         S_REM: begin
            // quotient to reg 24 now, remainder written on the way out
            r_we = a_ok; r_wa = QUOT_REG;
            r_wd = (b_ff == '0) ? '1 : dv_q;
            out_in = pack_out(8'(pc_ff), a_ok, a_ok ? QUOT_REG : 5'd0,
                              a_ok ? r_wd : '0,
                              32'(REM_REG) < NUM_REGS,
                              (32'(REM_REG) < NUM_REGS) ?
                                 ((b_ff == '0) ? a_ff : dv_r) : '0,
                              1'b0, '0, '0);
            state_in = S_OUT;
         end
         S_OUT: begin
            if (typ_ff == REQ_EXEC && ent_ff.op == OP_RTYPE &&
                ent_ff.fn == FN_DIV && out_ff[46]) begin
               r_we = 1'b1; r_wa = REM_REG; r_wd = out_ff[78:47];
            end
            out_v_in = 1'b1;
            state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         clr_ff   <= '0;
         pc_ff    <= '0;
         out_v_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         clr_ff   <= clr_in;
         pc_ff    <= pc_in;
         out_v_ff <= out_v_in;
      end
      out_ff <= out_in;
      if (req_tvalid && req_tready) begin
         req_ff <= req_tdata;
         typ_ff <= req_tuser;
         ent_ff <= '0;
      end
      if (state_ff == S_DEC) ent_ff <= m_rd;
      if (state_ff == S_REGS) a_ff <= (32'(ent_ff.ra) < NUM_REGS) ? r_rd : '0;
      if (state_ff == S_EXE)
         b_ff <= (32'(ent_ff.rb) < NUM_REGS) ? r_rd : '0;
   end

   assign rsp_tvalid = out_v_ff;
   assign rsp_tdata  = out_ff;

`ifndef NO_ASSERTIONS
   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (state_ff != S_IDLE) |-> !req_tready)
      else $error("request accepted while busy");
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> (rsp_tvalid && $stable(rsp_tdata)))
      else $error("result changed while stalled");
   a_div_only_wait: assert property (@(posedge clock) disable iff (reset)
      dv_done |-> (state_ff == S_DIVW))
      else $error("divider finished outside its wait");
`endif
endmodule
